### sv/psm_pkg.sv
// Shared types, widths and codes for the peak supply monitor.
// No dependencies; compiled first.
package psm_pkg;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 16;
    localparam int PEAK_W     = 10;
    localparam int REF_W      = 12;
    localparam int SUPPLY_W   = 16;
    localparam int SMOOTH_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Largest kept peak
    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    // Parameter defaults
    localparam int ADC_BITS_DEF    = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [REF_W-1:0]    REF_MV_RST     = REF_W'(1100);
    localparam logic [SUPPLY_W-1:0] LOW_THR_RST    = SUPPLY_W'(2300);
    localparam logic [GAIN_W-1:0]   FALL_GAIN_RST  = GAIN_W'(6554);
    localparam logic [GAIN_W-1:0]   RISE_GAIN_RST  = GAIN_W'(655);

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_LOAD   = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFERENCE = 3'd0,
        CFG_LOW_THR   = 3'd1,
        CFG_FALL_GAIN = 3'd2,
        CFG_RISE_GAIN = 3'd3,
        CFG_SMOOTH_EN = 3'd4
    } t_cfg_idx;

    // Back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MULT,
        ST_SUM,
        ST_DONE
    } t_back_state;

    // Queue entry: a stop carries the peak snapshot, a load its seed
    typedef struct packed {
        logic               is_load;
        logic [VALUE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // Current configuration
    typedef struct packed {
        logic [REF_W-1:0]    reference_mv;
        logic [SUPPLY_W-1:0] low_threshold_mv;
        logic [GAIN_W-1:0]   fall_gain_q16;
        logic [GAIN_W-1:0]   rise_gain_q16;
        logic                smooth_enable;
    } t_cfg;

endpackage

### sv/psm_ifs.sv
// Channel interfaces of the peak supply monitor: input items, results, config writes.
// Depends on psm_pkg.
interface psm_in_if
    import psm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface psm_out_if
    import psm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SUPPLY_W-1:0] supply_mv;
    logic                low_battery;
    logic [SMOOTH_W-1:0] smoothed_q8;
    logic [PEAK_W-1:0]   peak_reading;

    modport source (output valid, output supply_mv, output low_battery,
                    output smoothed_q8, output peak_reading, input ready);
    modport sink   (input valid, input supply_mv, input low_battery,
                    input smoothed_q8, input peak_reading, output ready);
endinterface

interface psm_cfg_if
    import psm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/psm_queue.sv
// Small flip-flop FIFO between the front and back ends.
// Depends on nothing; DEPTH must be a power of two.
module psm_queue #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (pop_ok)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (push_ok && !pop_ok)      r_count <= r_count + CNT_W'(1);
            else if (pop_ok && !push_ok) r_count <= r_count - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr_ptr] <= i_data;
    end
endmodule

### sv/psm_front.sv
// Front end: accepts items, tracks the peak reading, queues stops and loads.
// Depends on psm_pkg and psm_in_if.
module psm_front
    import psm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psm_in_if.sink       i_in,
    input  logic         i_q_full,
    output t_push        o_push
);
    localparam logic [VALUE_W-1:0] ADC_MASK = VALUE_W'((1 << ADC_BITS) - 1);

    logic [PEAK_W-1:0]  r_peak;
    logic [PEAK_W-1:0]  n_peak;
    logic               accept;
    logic [VALUE_W-1:0] reading;
    logic [PEAK_W-1:0]  reading_sat;
    t_mode              mode;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign mode       = t_mode'(i_in.mode);

    // Reading limited to ADC width, then to the peak width
    assign reading     = i_in.value & ADC_MASK;
    assign reading_sat = (reading > VALUE_W'(PEAK_MAX)) ? PEAK_MAX : reading[PEAK_W-1:0];

    // Peak update and queue push
    always_comb begin
        n_peak                 = r_peak;
        o_push.valid           = 1'b0;
        o_push.cmd.is_load     = 1'b0;
        o_push.cmd.data        = VALUE_W'(r_peak);
        if (accept) begin
            unique case (mode)
                MODE_SAMPLE: begin
                    if (reading_sat > r_peak) n_peak = reading_sat;
                end
                MODE_START: begin
                    n_peak = '0;
                end
                MODE_STOP: begin
                    o_push.valid = 1'b1;
                end
                MODE_LOAD: begin
                    o_push.valid       = 1'b1;
                    o_push.cmd.is_load = 1'b1;
                    o_push.cmd.data    = i_in.value;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end
endmodule

### sv/psm_back.sv
// Back end: restoring divide for the supply, smoothing update, result register.
// Depends on psm_pkg and psm_out_if.
module psm_back
    import psm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_cmd         i_cmd,
    input  logic         i_q_empty,
    output logic         o_pop,
    psm_out_if.source    o_out
);
    localparam int NUM_W  = REF_W + ADC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int PROD_W = SMOOTH_W + GAIN_W + 2;

    t_back_state r_state;
    t_back_state n_state;

    logic [NUM_W-1:0]    r_quo;
    logic [PEAK_W:0]     r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [PEAK_W-1:0]   r_peak;
    logic [SMOOTH_W-1:0] r_smooth;
    logic signed [PROD_W-1:0] r_prod;

    logic                r_out_valid;
    logic [SUPPLY_W-1:0] r_out_supply;
    logic                r_out_low;
    logic [SMOOTH_W-1:0] r_out_smooth;
    logic [PEAK_W-1:0]   r_out_peak;

    // Sequencer controls
    logic pop_load, pop_stop, div_step, mult_en, sum_en, out_load, out_free;

    logic [PEAK_W:0]          rem_sh;
    logic                     rem_ge;
    logic [SUPPLY_W-1:0]      supply;
    logic [SMOOTH_W-1:0]      fresh;
    logic [GAIN_W-1:0]        gain;
    logic signed [SMOOTH_W:0] diff;
    logic signed [PROD_W-1:0] sum;

    assign out_free = !r_out_valid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && !i_cmd.is_load) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) n_state = i_cfg.smooth_enable ? ST_MULT : ST_DONE;
            end
            ST_MULT: n_state = ST_SUM;
            ST_SUM:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        pop_load = 1'b0;
        pop_stop = 1'b0;
        div_step = 1'b0;
        mult_en  = 1'b0;
        sum_en   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                pop_load = !i_q_empty && i_cmd.is_load;
                pop_stop = !i_q_empty && !i_cmd.is_load;
            end
            ST_DIV:  div_step = 1'b1;
            ST_MULT: mult_en  = 1'b1;
            ST_SUM:  sum_en   = 1'b1;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    assign o_pop = pop_load || pop_stop;

    // One quotient bit per cycle
    assign rem_sh = {r_rem[PEAK_W-1:0], r_quo[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_peak});

    // Supply: zero for zero peak, saturated quotient otherwise
    always_comb begin
        if (r_peak == '0)                  supply = '0;
        else if (r_quo[NUM_W-1:SUPPLY_W] != '0) supply = '1;
        else                               supply = r_quo[SUPPLY_W-1:0];
    end

    // Smoothing: old + (fresh - old) * g, g in Q16, rounded, average in Q8
    assign fresh = {supply, 8'b0};
    assign gain  = (fresh < r_smooth) ? i_cfg.fall_gain_q16 : i_cfg.rise_gain_q16;
    assign diff  = $signed({1'b0, fresh}) - $signed({1'b0, r_smooth});
    assign sum   = $signed({2'b0, r_smooth, 16'b0}) + r_prod + PROD_W'(32768);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (pop_stop) begin
            r_peak <= i_cmd.data[PEAK_W-1:0];
            r_quo  <= NUM_W'(i_cfg.reference_mv) << ADC_BITS;
            r_rem  <= '0;
        end else if (div_step) begin
            r_quo <= {r_quo[NUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_peak}) : rem_sh;
        end
        if (mult_en) r_prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));
        if (out_load) begin
            r_out_supply <= supply;
            r_out_low    <= (supply <= i_cfg.low_threshold_mv);
            r_out_smooth <= r_smooth;
            r_out_peak   <= r_peak;
        end
    end

    // Control state, divide counter, smoothed average, result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop_stop)      r_cnt <= CNT_W'(NUM_W);
            else if (div_step) r_cnt <= r_cnt - CNT_W'(1);
            if (pop_load)    r_smooth <= {i_cmd.data, 8'b0};
            else if (sum_en) r_smooth <= sum[SMOOTH_W+15:16];
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.supply_mv    = r_out_supply;
    assign o_out.low_battery  = r_out_low;
    assign o_out.smoothed_q8  = r_out_smooth;
    assign o_out.peak_reading = r_out_peak;
endmodule

### sv/peak_supply_monitor.sv
// Peak supply monitor: items are accepted 1 per cycle, back to back, while the queue has room.
// A stop is popped by the back end once it is idle and the stop is at the head of the queue;
// its result is registered after the one-bit-per-cycle divide, the multiply and sum steps
// (skipped with smoothing off) and the done state; the back end retires one stop at a time.
// A load is applied on pop; QUEUE_DEPTH queued stops/loads fill the queue, then input stalls.
// Synchronous active-low reset clears peak, average, config to defaults and all control.
module peak_supply_monitor
    import psm_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psm_cfg_if.sink    i_cfg,
    psm_in_if.sink     i_in,
    psm_out_if.source  o_out
);
    t_cfg  r_cfg;
    t_push push;
    t_cmd  head;
    logic  q_full;
    logic  q_empty;
    logic  pop;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_mv     <= REF_MV_RST;
            r_cfg.low_threshold_mv <= LOW_THR_RST;
            r_cfg.fall_gain_q16    <= FALL_GAIN_RST;
            r_cfg.rise_gain_q16    <= RISE_GAIN_RST;
            r_cfg.smooth_enable    <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_REFERENCE: r_cfg.reference_mv     <= i_cfg.data[REF_W-1:0];
                CFG_LOW_THR:   r_cfg.low_threshold_mv <= i_cfg.data;
                CFG_FALL_GAIN: r_cfg.fall_gain_q16    <= i_cfg.data;
                CFG_RISE_GAIN: r_cfg.rise_gain_q16    <= i_cfg.data;
                CFG_SMOOTH_EN: r_cfg.smooth_enable    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    psm_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    psm_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push.valid),
        .i_data  (push.cmd),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    psm_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (head),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule

### sim/testbench.sv
// Self-checking testbench for peak_supply_monitor: directed and random item streams
// under random idling, predicted results compared field by field.
// Depends on psm_pkg, psm_ifs and the peak_supply_monitor RTL.
module testbench;
    import psm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control
    localparam int SETTLE_CYCLES  = 64;     // extra wait after a drain; loads queue behind a stop in progress
    localparam int STALL_LIMIT    = 4000;   // cycles with no beat on any channel
    localparam int RANDOM_PHASES  = 10;
    localparam int ITEMS_PER_PHASE = 75;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct {
        t_mode                mode;
        logic [VALUE_W-1:0]   value;
    } t_supply_item;

    typedef struct {
        logic [SUPPLY_W-1:0]  supply_mv;
        logic                 low_battery;
        logic [SMOOTH_W-1:0]  smoothed_q8;
        logic [PEAK_W-1:0]    peak_reading;
    } t_supply_report;

    logic i_clk;
    logic i_rst_n;

    psm_in_if  in_if();
    psm_out_if out_if();
    psm_cfg_if cfg_if();

    peak_supply_monitor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_supply_item   pending_items[$];
    t_supply_report reports_due[$];

    // Predictor state: registers, kept peak and smoothed average
    t_cfg               regs_model;
    logic [PEAK_W-1:0]  peak_model;
    logic [SMOOTH_W-1:0] avg_q8_model;

    int error_count;
    int items_sent;
    int reports_checked;
    int register_writes;
    int idle_cycles;
    int send_gap;
    int send_calm;
    int take_stall;
    int take_calm;
    t_supply_item next_beat;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random idle length: mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // Supply from the peak, low flag and smoothing update for a stop
    function automatic t_supply_report predict_stop();
        t_supply_report rep;
        longint unsigned quot;
        longint unsigned fresh;
        longint unsigned old;
        longint unsigned gain;
        longint unsigned acc;
        if (peak_model == '0) begin
            quot = 0;
        end else begin
            quot = (longint'(regs_model.reference_mv) << ADC_BITS_DEF) / longint'(peak_model);
        end
        if (quot > 65535) quot = 65535;
        rep.supply_mv = SUPPLY_W'(quot);
        rep.low_battery = (rep.supply_mv <= regs_model.low_threshold_mv);
        if (regs_model.smooth_enable) begin
            fresh = longint'(rep.supply_mv) << 8;
            old = longint'(avg_q8_model);
            gain = (fresh < old) ? longint'(regs_model.fall_gain_q16)
                                 : longint'(regs_model.rise_gain_q16);
            acc = old * (65536 - gain) + fresh * gain + 32768;
            avg_q8_model = SMOOTH_W'(acc >> 16);
        end
        rep.smoothed_q8 = avg_q8_model;
        rep.peak_reading = peak_model;
        return rep;
    endfunction

    // Advance the predictor by one accepted item
    task automatic predict_monitor_item(input t_mode mode, input logic [VALUE_W-1:0] value);
        longint unsigned reading;
        case (mode)
            MODE_SAMPLE: begin
                reading = longint'(value) & ((64'd1 << ADC_BITS_DEF) - 1);
                if (reading > longint'(PEAK_MAX)) reading = longint'(PEAK_MAX);
                if (reading > longint'(peak_model)) peak_model = PEAK_W'(reading);
            end
            MODE_START: peak_model = '0;
            MODE_LOAD:  avg_q8_model = SMOOTH_W'(longint'(value) << 8);
            MODE_STOP:  reports_due.push_back(predict_stop());
            default: ;
        endcase
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] word);
        case (t_cfg_idx'(idx))
            CFG_REFERENCE: regs_model.reference_mv     = word[REF_W-1:0];
            CFG_LOW_THR:   regs_model.low_threshold_mv = word;
            CFG_FALL_GAIN: regs_model.fall_gain_q16    = word;
            CFG_RISE_GAIN: regs_model.rise_gain_q16    = word;
            CFG_SMOOTH_EN: regs_model.smooth_enable    = word[0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_report();
        t_supply_report want;
        if (reports_due.size() == 0) begin
            $error("result beat with no stop outstanding: supply_mv %0d", out_if.supply_mv);
            error_count++;
        end else begin
            want = reports_due.pop_front();
            compare_field("supply_mv", want.supply_mv, out_if.supply_mv);
            compare_field("low_battery", want.low_battery, out_if.low_battery);
            compare_field("smoothed_q8", want.smoothed_q8, out_if.smoothed_q8);
            compare_field("peak_reading", want.peak_reading, out_if.peak_reading);
            reports_checked++;
        end
    endtask

    // Monitor: config beats, input beats, result beats and the watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs_model = '{REF_MV_RST, LOW_THR_RST, FALL_GAIN_RST, RISE_GAIN_RST, 1'b1};
            peak_model = '0;
            avg_q8_model = '0;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (cfg_if.valid && cfg_if.ready) begin
                apply_register(cfg_if.index, cfg_if.data);
                register_writes++;
                idle_cycles = 0;
            end
            if (in_if.valid && in_if.ready) begin
                predict_monitor_item(t_mode'(in_if.mode), in_if.value);
                idle_cycles = 0;
            end
            if (out_if.valid && out_if.ready) begin
                check_report();
                idle_cycles = 0;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, reports_due.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Driver for the item channel, fed from pending_items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.mode  <= MODE_SAMPLE;
            in_if.value <= '0;
            send_gap = 0;
            send_calm = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_beat = pending_items.pop_front();
                in_if.valid <= 1'b1;
                in_if.mode  <= next_beat.mode;
                in_if.value <= next_beat.value;
                items_sent++;
                if (send_calm > 0) begin
                    send_calm--;
                end else if ($urandom_range(0, 49) == 0) begin
                    send_calm = $urandom_range(20, 80);
                end else if ($urandom_range(0, 2) == 0) begin
                    send_gap = idle_length();
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result channel back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_stall = 0;
            take_calm = 0;
        end else if (take_stall > 0) begin
            take_stall--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (take_calm > 0) begin
                take_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
                take_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 3) == 0) begin
                take_stall = idle_length();
            end
        end
    end

    task automatic queue_item(input t_mode mode, input logic [VALUE_W-1:0] value);
        t_supply_item it;
        it.mode = mode;
        it.value = value;
        pending_items.push_back(it);
    endtask

    // ADC readings: mostly plausible bandgap codes, some tiny, near full scale or oversized
    function automatic logic [VALUE_W-1:0] adc_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return VALUE_W'($urandom_range(0, 65535));
        if (r == 1) return VALUE_W'($urandom_range(0, 3));
        if (r == 2) return VALUE_W'($urandom_range(1000, 1023));
        return VALUE_W'($urandom_range(150, 700));
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] word);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= word;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Hold off until every queued item went in and every report came back
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || in_if.valid || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Phase 1 and 2 use the extremes, the rest random settings
    task automatic set_registers(input int phase);
        logic [CFG_DATA_W-1:0] ref_word;
        logic [CFG_DATA_W-1:0] thr_word;
        if (phase == 1) begin
            write_register(CFG_REFERENCE, 16'hFFFF);
            write_register(CFG_LOW_THR, 16'hFFFF);
            write_register(CFG_FALL_GAIN, 16'hFFFF);
            write_register(CFG_RISE_GAIN, 16'h0000);
            write_register(CFG_SMOOTH_EN, 16'h0001);
        end else if (phase == 2) begin
            write_register(CFG_REFERENCE, 16'h0000);
            write_register(CFG_LOW_THR, 16'h0000);
            write_register(CFG_FALL_GAIN, 16'h0000);
            write_register(CFG_RISE_GAIN, 16'hFFFF);
            write_register(CFG_SMOOTH_EN, 16'hFFFE);
        end else begin
            ref_word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                                   : CFG_DATA_W'($urandom_range(800, 1300));
            thr_word = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(1500, 4000))
                                                   : CFG_DATA_W'($urandom_range(0, 65535));
            write_register(CFG_REFERENCE, ref_word);
            write_register(CFG_LOW_THR, thr_word);
            write_register(CFG_FALL_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
            write_register(CFG_RISE_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
            write_register(CFG_SMOOTH_EN, CFG_DATA_W'($urandom_range(0, 65535)));
        end
        // an undecoded index must leave every register alone
        write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                       CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    // Mostly start / samples / stop windows, plus loads and stray items
    task automatic queue_random_items(input int count);
        int target;
        int kind;
        int burst;
        target = pending_items.size() + count;
        while (pending_items.size() < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                queue_item(MODE_START, VALUE_W'($urandom_range(0, 65535)));
                burst = $urandom_range(1, 8);
                repeat (burst) queue_item(MODE_SAMPLE, adc_value());
                queue_item(MODE_STOP, VALUE_W'($urandom_range(0, 65535)));
                if ($urandom_range(0, 4) == 0)
                    queue_item(MODE_STOP, VALUE_W'($urandom_range(0, 65535)));
            end else if (kind == 6) begin
                queue_item(MODE_LOAD, VALUE_W'($urandom_range(0, 65535)));
            end else if (kind == 7) begin
                queue_item(MODE_LOAD, VALUE_W'($urandom_range(1500, 5000)));
            end else if (kind == 8) begin
                queue_item(MODE_SAMPLE, adc_value());
            end else begin
                queue_item(t_mode'($urandom_range(0, 3)), VALUE_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    // Stimulus and end of run
    initial begin
        error_count = 0;
        items_sent = 0;
        reports_checked = 0;
        register_writes = 0;
        i_rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_REFERENCE;
        cfg_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero peak, saturation, oversized samples, repeated stop,
        // falling and rising average, threshold edges, samples outside a window
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_LOAD, 16'hFFFF);
        queue_item(MODE_SAMPLE, 16'd1);
        queue_item(MODE_STOP, 16'hFFFF);
        queue_item(MODE_START, 16'hFFFF);
        queue_item(MODE_SAMPLE, 16'hFFFF);
        queue_item(MODE_SAMPLE, 16'h0400);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_LOAD, 16'h0000);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_START, 16'h0000);
        queue_item(MODE_SAMPLE, 16'd300);
        queue_item(MODE_SAMPLE, 16'd512);
        queue_item(MODE_SAMPLE, 16'd200);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_START, 16'h0000);
        queue_item(MODE_SAMPLE, 16'd489);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_START, 16'h0000);
        queue_item(MODE_SAMPLE, 16'd490);
        queue_item(MODE_STOP, 16'h0000);
        queue_item(MODE_SAMPLE, 16'd1000);
        queue_item(MODE_STOP, 16'h0000);
        wait_for_drain();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            set_registers(phase);
            queue_random_items(ITEMS_PER_PHASE);
            wait_for_drain();
        end

        if (reports_due.size() != 0) begin
            $error("%0d expected results never arrived", reports_due.size());
            error_count++;
        end
        $display("summary: %0d items, %0d results checked, %0d register writes over %0d settings",
                 items_sent, reports_checked, register_writes, RANDOM_PHASES + 1);
        $display("summary: %0d mismatches or stray results", error_count);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
